// File: hw/rtl/deadline_sorted_timer_queue_core_macros.svh
// Assertion macros for the timer queue core.
`ifndef DEADLINE_SORTED_TIMER_QUEUE_CORE_MACROS_SVH
`define DEADLINE_SORTED_TIMER_QUEUE_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define DSTQ_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
`define DSTQ_ASSERT_NXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define DSTQ_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define DSTQ_ASSERT_NXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: hw/rtl/dstq_pkg.sv
package dstq_pkg;
	localparam int unsigned SLOTS_DEF   = 16;
	localparam int unsigned ID_BASE_DEF = 16;
	localparam logic [1:0] OP_START = 2'd0;
	localparam logic [1:0] OP_STOP  = 2'd1;
	localparam logic [1:0] OP_YIELD = 2'd2;
	localparam logic [1:0] KIND_DONE    = 2'd0;
	localparam logic [1:0] KIND_EXPIRED = 2'd1;
	localparam logic [1:0] KIND_REMAIN  = 2'd2;
	localparam logic [30:0] REM_MAX = 31'h7FFF_FFFF;

	typedef struct packed {
		logic [1:0]  opcode;
		logic [4:0]  timer_id;
		logic [31:0] duration;
		logic [31:0] now_time;
	} in_item_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [4:0]  expired_id;
		logic [30:0] remaining;
		logic        status;
		logic        last;
	} out_item_t;

	// Classified command handed from the front to the back.
	typedef struct packed {
		logic [1:0]  opcode;
		logic        id_ok;
		logic [7:0]  slot;
		logic [32:0] deadline;
		logic [31:0] now_time;
	} cmd_t;
endpackage

// File: hw/rtl/dstq_front.sv
module dstq_front #(
	parameter int unsigned SLOTS   = 16,
	parameter int unsigned ID_BASE = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	input  dstq_pkg::in_item_t in_item,
	input  logic               push,
	output logic               full,
	output dstq_pkg::cmd_t     cmd,
	output logic               cmd_valid,
	input  logic               cmd_take
);
	import dstq_pkg::*;

	// Two-entry queue of classified commands.
	cmd_t        buf_q [2];
	logic        wr_q, rd_q;
	logic [1:0]  cnt_q;
	cmd_t        cls;
	logic [8:0]  id_ext;
	logic [8:0]  off;
	logic        do_push, do_pop;

	always_comb begin
		id_ext = {4'd0, in_item.timer_id};
		off    = id_ext - 9'(ID_BASE);
		cls.opcode   = in_item.opcode;
		cls.id_ok    = (id_ext >= 9'(ID_BASE)) && (off < 9'(SLOTS));
		cls.slot     = off[7:0];
		cls.deadline = {1'b0, in_item.duration} + {1'b0, in_item.now_time};
		cls.now_time = in_item.now_time;
	end

	assign full      = cnt_q == 2'd2;
	assign cmd_valid = cnt_q != 2'd0;
	assign cmd       = buf_q[rd_q];
	assign do_push   = push && !full;
	assign do_pop    = cmd_take && cmd_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			buf_q[wr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (do_push) wr_q <= ~wr_q;
			if (do_pop)  rd_q <= ~rd_q;
			cnt_q <= cnt_q + 2'(do_push) - 2'(do_pop);
		end
	end
endmodule

// File: hw/rtl/dstq_back.sv
module dstq_back #(
	parameter int unsigned SLOTS   = 16,
	parameter int unsigned ID_BASE = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  dstq_pkg::cmd_t      cmd,
	input  logic                cmd_valid,
	output logic                cmd_take,
	output dstq_pkg::out_item_t res,
	output logic                empty,
	input  logic                pop
);
	import dstq_pkg::*;

	localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int unsigned CW = $clog2(SLOTS + 1);

	typedef enum logic [2:0] {
		ST_IDLE, ST_RM_SCAN, ST_RM_SHIFT, ST_INS_SCAN, ST_INS_SHIFT,
		ST_Y_HEAD, ST_Y_SHIFT, ST_OUT
	} state_t;

	logic [32:0]   dl_mem [SLOTS];
	logic [SW-1:0] ord_q  [SLOTS];
	state_t        state_q;
	cmd_t          c_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] i_q;
	logic [CW-1:0] pos_q;
	out_item_t     res_q;
	logic          full_q;
	logic          res_load;
	logic [SW-1:0] my_slot;
	logic [32:0]   dl_rd;
	logic [32:0]   diff;

	assign my_slot  = c_q.slot[SW-1:0];
	assign cmd_take = (state_q == ST_IDLE) && !full_q;
	assign empty    = !full_q;
	assign res      = res_q;
	assign dl_rd    = dl_mem[ord_q[i_q[SW-1:0]]];
	assign diff     = dl_rd - {1'b0, c_q.now_time};

	// A new result is loaded into the output register in these cases.
	always_comb begin
		res_load = 1'b0;
		case (state_q)
			ST_IDLE: begin
				res_load = cmd_valid && !full_q && cmd.opcode != OP_YIELD
					&& !((cmd.opcode == OP_START || cmd.opcode == OP_STOP) && cmd.id_ok);
			end
			ST_Y_HEAD: res_load = !full_q || pop;
			ST_OUT:    res_load = !full_q;
			default:   res_load = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd_take && cmd_valid && cmd.opcode == OP_START && cmd.id_ok) begin
			dl_mem[cmd.slot[SW-1:0]] <= cmd.deadline;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			i_q     <= '0;
			full_q  <= 1'b0;
		end else begin
			full_q <= res_load || (full_q && !pop);
			case (state_q)
				ST_IDLE: begin
					if (cmd_valid && !full_q) begin
						c_q <= cmd;
						i_q <= '0;
						if (cmd.opcode == OP_YIELD) begin
							state_q <= ST_Y_HEAD;
						end else if ((cmd.opcode == OP_START || cmd.opcode == OP_STOP)
								&& cmd.id_ok) begin
							state_q <= ST_RM_SCAN;
						end else begin
							res_q <= '{kind: KIND_DONE, expired_id: 5'd0, remaining: 31'd0,
								status: (cmd.opcode != OP_YIELD && cmd.opcode[1] == 1'b0),
								last: 1'b1};
						end
					end
				end
				ST_RM_SCAN: begin
					if (i_q == cnt_q) begin
						i_q <= '0;
						if (c_q.opcode == OP_START) begin
							state_q <= ST_INS_SCAN;
						end else begin
							state_q <= ST_OUT;
						end
					end else if (ord_q[i_q[SW-1:0]] == my_slot) begin
						state_q <= ST_RM_SHIFT;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				ST_RM_SHIFT: begin
					if (i_q + 1'b1 >= cnt_q) begin
						cnt_q   <= cnt_q - 1'b1;
						i_q     <= '0;
						state_q <= (c_q.opcode == OP_START) ? ST_INS_SCAN : ST_OUT;
					end else begin
						ord_q[i_q[SW-1:0]] <= ord_q[i_q[SW-1:0] + 1'b1];
						i_q <= i_q + 1'b1;
					end
				end
				ST_INS_SCAN: begin
					if (i_q == cnt_q || !(dl_rd < c_q.deadline)) begin
						state_q <= ST_INS_SHIFT;
						i_q     <= cnt_q;
						pos_q   <= i_q;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				ST_INS_SHIFT: begin
					if (i_q == pos_q) begin
						ord_q[i_q[SW-1:0]] <= my_slot;
						cnt_q   <= cnt_q + 1'b1;
						state_q <= ST_OUT;
					end else begin
						ord_q[i_q[SW-1:0]] <= ord_q[i_q[SW-1:0] - 1'b1];
						i_q <= i_q - 1'b1;
					end
				end
				ST_Y_HEAD: begin
					if (!full_q || pop) begin
						if (cnt_q != '0 && !(c_q.now_time < dl_rd)) begin
							res_q <= '{kind: KIND_EXPIRED,
								expired_id: 5'(ID_BASE + 32'(ord_q[0])),
								remaining: 31'd0, status: 1'b0, last: 1'b0};
							i_q     <= '0;
							state_q <= ST_Y_SHIFT;
						end else begin
							res_q <= '{kind: KIND_REMAIN, expired_id: 5'd0,
								remaining: (cnt_q == '0) ? 31'd0 :
									(diff[32:31] != 2'd0 ? REM_MAX : diff[30:0]),
								status: 1'b0, last: 1'b1};
							state_q <= ST_IDLE;
						end
					end
				end
				ST_Y_SHIFT: begin
					if (i_q + 1'b1 >= cnt_q) begin
						cnt_q   <= cnt_q - 1'b1;
						i_q     <= '0;
						state_q <= ST_Y_HEAD;
					end else begin
						ord_q[i_q[SW-1:0]] <= ord_q[i_q[SW-1:0] + 1'b1];
						i_q <= i_q + 1'b1;
					end
				end
				ST_OUT: begin
					if (!full_q) begin
						res_q <= '{kind: KIND_DONE, expired_id: 5'd0, remaining: 31'd0,
							status: 1'b0, last: 1'b1};
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule

// File: hw/rtl/deadline_sorted_timer_queue_core.sv
// Channel | Handshake       | Payload
// input   | push / full     | in_item  (opcode, timer_id, duration, now_time)
// result  | pop / empty     | out_item (kind, expired_id, remaining, status, last)
//
// A start or stop with a valid id passes from its transfer to its result in steps:
// it waits in the command queue, is taken, then a removal scan and shift over the
// ordered list, then for a start an insertion scan and shift, and the result load.
// A yield gives one expired result per due timer, each with a list shift, then the remainder.
// The back end walks the list for these steps; a two-entry command queue
// lets new items be accepted while the back end works or its result waits.
// Reset clears the list length and all handshake state at once.
module deadline_sorted_timer_queue_core #(
	parameter int unsigned SLOTS   = dstq_pkg::SLOTS_DEF,
	parameter int unsigned ID_BASE = dstq_pkg::ID_BASE_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  dstq_pkg::in_item_t  in_item,
	input  logic                push,
	output logic                full,
	output dstq_pkg::out_item_t out_item,
	output logic                empty,
	input  logic                pop
);
	import dstq_pkg::*;
`include "deadline_sorted_timer_queue_core_macros.svh"

	cmd_t cmd;
	logic cmd_valid, cmd_take;

	// The front classifies each transfer and computes the 33-bit deadline.
	dstq_front #(.SLOTS(SLOTS), .ID_BASE(ID_BASE)) u_front (
		.clk, .arst_n, .in_item, .push, .full,
		.cmd, .cmd_valid, .cmd_take
	);

	// The back walks the ordered list and produces the result transfers.
	dstq_back #(.SLOTS(SLOTS), .ID_BASE(ID_BASE)) u_back (
		.clk, .arst_n, .cmd, .cmd_valid, .cmd_take,
		.res(out_item), .empty, .pop
	);

	`DSTQ_ASSERT_IMP(a_remain_last, clk, arst_n,
		!empty && out_item.kind == KIND_REMAIN, out_item.last)
	`DSTQ_ASSERT_IMP(a_kind_legal, clk, arst_n, !empty, out_item.kind != 2'd3)
	`DSTQ_ASSERT_IMP(a_exp_not_last, clk, arst_n,
		!empty && out_item.kind == KIND_EXPIRED, !out_item.last)
	`DSTQ_ASSERT_NXT(a_hold, clk, arst_n, !empty && !pop, !empty && $stable(out_item))
endmodule
